[sv/rlpl_pkg.sv]
package rlpl_pkg;

    localparam int RLPL_ENTRIES = 32;

    localparam logic [5:0] MAX_PLEN = 6'd32;

    // input selector codes
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // one table entry as stored in the route RAM
    typedef struct packed {
        logic [31:0] dest;
        logic [5:0]  len;
        logic [31:0] gateway;
        logic [3:0]  port;
    } t_route;

    // scan control toward the match unit
    typedef struct packed {
        logic clr;  // new lookup: drop previous candidates
        logic vld;  // RAM read data is valid this cycle
    } t_match_ctl;

    // top len bits set; len is at most 32 when stored
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'h0;
        end else if (len >= MAX_PLEN) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = ~(32'hFFFF_FFFF >> len);
        end
        return m;
    endfunction

endpackage

[sv/route_longest_prefix_lookup.sv]
// Route table with longest-prefix lookup. Issue a word with start while busy
// is low; func picks add (0), lookup (1) or clear (2). Every word gives exactly
// one result on the o_ ports, shown for a single cycle with o_strobe high; the
// result cannot be held off, so capture it on that cycle. Add, clear and the
// unused selector finish at once: result in the next cycle, and busy stays low,
// so such words may be issued every cycle. A lookup walks the stored routes
// one slot per cycle through the single read port of the route RAM, then
// enters the done state; busy is high through the scan and the done state,
// and the result is registered as the block leaves the done state. On an
// empty table there is no walk: the lookup goes straight to the done state.
// Adds append to the next free slot; clear only resets the fill count, so it
// needs no sweep of the RAM.
module route_longest_prefix_lookup
    import rlpl_pkg::*;
#(
    parameter int ENTRIES = RLPL_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    input  logic [31:0] i_next_hop,
    input  logic [3:0]  i_intf_id,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [31:0] o_route_next_hop,
    output logic [3:0]  o_route_intf,
    output logic [5:0]  o_route_prefix_len,
    output logic        o_used_default
);

    localparam int IW = $clog2(ENTRIES);       // slot index width
    localparam int CW = $clog2(ENTRIES + 1);   // fill count width

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_issue, n_issue;   // scan still issuing reads
    logic          r_pend;             // read data arrives this cycle
    logic          r_strobe, n_strobe;

    // scan payload
    logic [IW-1:0] r_addr, n_addr;     // next slot to read
    logic [IW-1:0] r_pidx;             // slot of the data now on the RAM output
    logic [IW-1:0] r_last_idx, n_last_idx;
    logic [31:0]   r_key, n_key;

    // result word
    logic [1:0]    r_status, n_status;
    logic [4:0]    r_slot, n_slot;
    logic [31:0]   r_nh, n_nh;
    logic [3:0]    r_intf, n_intf;
    logic [5:0]    r_plen, n_plen;
    logic          r_def, n_def;

    logic          accept, add_ok, rd_en;
    logic [5:0]    sat_len;
    t_route        wr_route, rd_route;
    t_match_ctl    mctl;

    logic          m_found, m_default;
    logic [IW-1:0] m_idx;
    logic [31:0]   m_nh;
    logic [3:0]    m_intf;
    logic [5:0]    m_len;

    // slot field is the low five bits of the index
    logic [IW+4:0] add_slot_ext, hit_slot_ext;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign add_ok = accept && (i_func == FUNC_ADD) && (r_count < CW'(ENTRIES));
    assign rd_en  = (r_state == S_SCAN) && r_issue;

    assign sat_len = (i_prefix_len > MAX_PLEN) ? MAX_PLEN : i_prefix_len;

    always_comb begin
        wr_route.dest    = i_address;
        wr_route.len     = sat_len;
        wr_route.gateway = i_next_hop;
        wr_route.port    = i_intf_id;
    end

    assign add_slot_ext = {5'b0, r_count[IW-1:0]};
    assign hit_slot_ext = {5'b0, m_idx};

    assign mctl.clr = accept && (i_func == FUNC_LOOKUP);
    assign mctl.vld = r_pend;

    rlpl_ram #(
        .WIDTH ($bits(t_route)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (add_ok),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (wr_route),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_route)
    );

    rlpl_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mctl),
        .i_idx      (r_pidx),
        .i_route    (rd_route),
        .i_key      (r_key),
        .o_found    (m_found),
        .o_idx      (m_idx),
        .o_next_hop (m_nh),
        .o_intf     (m_intf),
        .o_len      (m_len),
        .o_default  (m_default)
    );

    // next state and result word
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_issue    = r_issue;
        n_addr     = r_addr;
        n_last_idx = r_last_idx;
        n_key      = r_key;
        n_strobe   = 1'b0;
        n_status   = STATUS_OK;
        n_slot     = 5'd0;
        n_nh       = 32'h0;
        n_intf     = 4'd0;
        n_plen     = 6'd0;
        n_def      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_ADD: begin
                            n_strobe = 1'b1;
                            if (add_ok) begin
                                n_count = r_count + CW'(1);
                                n_slot  = add_slot_ext[4:0];
                                n_nh    = i_next_hop;
                                n_intf  = i_intf_id;
                                n_plen  = sat_len;
                                n_def   = (i_address == 32'h0);
                            end else begin
                                n_status = STATUS_FULL;
                            end
                        end
                        FUNC_LOOKUP: begin
                            n_key = i_address;
                            if (r_count == CW'(0)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state    = S_SCAN;
                                n_issue    = 1'b1;
                                n_addr     = '0;
                                n_last_idx = IW'(r_count - CW'(1));
                            end
                        end
                        FUNC_CLEAR: begin
                            n_strobe = 1'b1;
                            n_count  = '0;
                        end
                        default: begin
                            // unused selector: plain ok, table untouched
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    n_addr = r_addr + IW'(1);
                    if (r_addr == r_last_idx) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_pend && (r_pidx == r_last_idx)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                if (m_found) begin
                    n_slot = hit_slot_ext[4:0];
                    n_nh   = m_nh;
                    n_intf = m_intf;
                    n_plen = m_len;
                    n_def  = m_default;
                end else begin
                    n_status = STATUS_MISS;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_issue  <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_pend   <= rd_en;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pidx     <= r_addr;
        r_last_idx <= n_last_idx;
        r_key      <= n_key;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_nh       <= n_nh;
        r_intf     <= n_intf;
        r_plen     <= n_plen;
        r_def      <= n_def;
    end

    assign o_strobe           = r_strobe;
    assign o_status           = r_status;
    assign o_slot             = r_slot;
    assign o_route_next_hop   = r_nh;
    assign o_route_intf       = r_intf;
    assign o_route_prefix_len = r_plen;
    assign o_used_default     = r_def;

    // fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("route count beyond table size");

    // no read data may be pending outside a scan
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("read data pending outside scan");

    // a lookup on a non-empty table must start a scan
    a_lookup_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_LOOKUP) && (r_count != CW'(0)))
        |=> (r_state == S_SCAN) && r_issue)
        else $error("lookup did not start scan");

    // a table-full result only when the table really is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STATUS_FULL)) |-> (r_count == CW'(ENTRIES)))
        else $error("full status with free slots");

    // the scan result strobes exactly after the done state
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_strobe && (r_state == S_IDLE))
        else $error("lookup result not delivered");

endmodule

[sv/rlpl_ram.sv]
module rlpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rlpl_match.sv]
module rlpl_match
    import rlpl_pkg::*;
#(
    parameter int ENTRIES = RLPL_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_match_ctl                   i_ctl,
    input  logic [$clog2(ENTRIES)-1:0]   i_idx,
    input  t_route                       i_route,
    input  logic [31:0]                  i_key,
    output logic                         o_found,
    output logic [$clog2(ENTRIES)-1:0]   o_idx,
    output logic [31:0]                  o_next_hop,
    output logic [3:0]                   o_intf,
    output logic [5:0]                   o_len,
    output logic                         o_default
);

    localparam int IW = $clog2(ENTRIES);

    logic          r_have_best, r_have_def;
    logic [IW-1:0] r_best_idx, r_def_idx;
    logic [31:0]   r_best_gw, r_def_gw;
    logic [3:0]    r_best_port, r_def_port;
    logic [5:0]    r_best_len, r_def_len;

    logic is_def, hit;

    always_comb begin
        is_def = (i_route.dest == 32'h0);
        // later slots win ties, so >= on the length
        hit = !is_def && (i_route.len != 6'd0)
            && (((i_key ^ i_route.dest) & prefix_mask(i_route.len)) == 32'h0)
            && (!r_have_best || (i_route.len >= r_best_len));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_have_def  <= 1'b0;
        end else if (i_ctl.clr) begin
            r_have_best <= 1'b0;
            r_have_def  <= 1'b0;
        end else if (i_ctl.vld) begin
            if (hit) begin
                r_have_best <= 1'b1;
            end
            if (is_def) begin
                r_have_def <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld && !i_ctl.clr) begin
            if (hit) begin
                r_best_idx  <= i_idx;
                r_best_gw   <= i_route.gateway;
                r_best_port <= i_route.port;
                r_best_len  <= i_route.len;
            end
            // first default route only
            if (is_def && !r_have_def) begin
                r_def_idx  <= i_idx;
                r_def_gw   <= i_route.gateway;
                r_def_port <= i_route.port;
                r_def_len  <= i_route.len;
            end
        end
    end

    assign o_found    = r_have_best || r_have_def;
    assign o_default  = !r_have_best;
    assign o_idx      = r_have_best ? r_best_idx  : r_def_idx;
    assign o_next_hop = r_have_best ? r_best_gw   : r_def_gw;
    assign o_intf     = r_have_best ? r_best_port : r_def_port;
    assign o_len      = r_have_best ? r_best_len  : r_def_len;

endmodule

[dv/route_longest_prefix_lookup_tb.sv]
`timescale 1ns / 100ps

module route_longest_prefix_lookup_tb;
    import rlpl_pkg::*;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int          ROUTE_SLOTS = RLPL_ENTRIES;
    localparam logic [1:0]  FUNC_NONE   = 2'd3;   // unused selector, ignored by the block
    localparam int          RAND_ITEMS  = 1030;
    localparam int          QUIET_LIMIT = 1000;   // cycles with no word in or out
    localparam int          TAIL_CYCLES = 40;     // covers a lookup on a full table

    // ------------------------------------------------------------------
    // Word and result layouts
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] next_hop;
        logic [3:0]  intf_id;
    } t_route_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [31:0] next_hop;
        logic [3:0]  intf;
        logic [5:0]  prefix_len;
        logic        used_default;
    } t_route_result;

    // one directed row: the word, and a hand-written result where it is obvious
    typedef struct packed {
        t_route_cmd    cmd;
        logic          pinned;
        t_route_result res;
    } t_directed_row;

    localparam t_route_result BLANK_OK = '{STATUS_OK, 5'd0, 32'd0, 4'd0, 6'd0, 1'b0};
    localparam t_route_result NO_ROUTE = '{STATUS_MISS, 5'd0, 32'd0, 4'd0, 6'd0, 1'b0};

    localparam int DIR_ROWS = 21;

    // Directed sequence: empty table, ignored selector, ties, default routes,
    // zero-length non-default route, saturated length, clear.
    t_directed_row directed_rows [DIR_ROWS] = '{
        '{'{FUNC_LOOKUP, 32'hC0A8_0101, 6'd0,  32'd0,         4'd0}, 1'b1, NO_ROUTE},
        '{'{FUNC_NONE,   32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 4'hF}, 1'b1, BLANK_OK},
        '{'{FUNC_CLEAR,  32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 4'hF}, 1'b1, BLANK_OK},
        '{'{FUNC_ADD,    32'h0A00_0000, 6'd8,  32'h0A00_00FE, 4'd1}, 1'b0, '0},
        '{'{FUNC_ADD,    32'h0A01_0000, 6'd16, 32'd0,         4'd2}, 1'b0, '0},
        '{'{FUNC_ADD,    32'h0A01_0000, 6'd16, 32'h0101_0101, 4'd3}, 1'b0, '0},
        '{'{FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  32'd0,         4'd0}, 1'b0, '0},
        '{'{FUNC_LOOKUP, 32'h0AFF_0000, 6'd0,  32'd0,         4'd0}, 1'b0, '0},
        '{'{FUNC_LOOKUP, 32'h0B00_0000, 6'd0,  32'd0,         4'd0}, 1'b1, NO_ROUTE},
        '{'{FUNC_ADD,    32'h0000_0000, 6'd0,  32'hC0A8_0001, 4'd4}, 1'b0, '0},
        '{'{FUNC_ADD,    32'h0000_0000, 6'd5,  32'h0000_DEAD, 4'd5}, 1'b0, '0},
        '{'{FUNC_ADD,    32'hFFFF_FFFF, 6'd0,  32'h1212_1212, 4'd6}, 1'b0, '0},
        '{'{FUNC_ADD,    32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 4'hF}, 1'b1,
          '{STATUS_OK, 5'd6, 32'hFFFF_FFFF, 4'hF, 6'd32, 1'b0}},
        '{'{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'd0,         4'd0}, 1'b0, '0},
        '{'{FUNC_LOOKUP, 32'h0B00_0000, 6'd0,  32'd0,         4'd0}, 1'b0, '0},
        '{'{FUNC_LOOKUP, 32'h7F00_0000, 6'd0,  32'd0,         4'd0}, 1'b0, '0},
        '{'{FUNC_ADD,    32'h8000_0000, 6'd1,  32'h1234_5678, 4'd8}, 1'b0, '0},
        '{'{FUNC_LOOKUP, 32'h8000_0001, 6'd0,  32'd0,         4'd0}, 1'b0, '0},
        '{'{FUNC_CLEAR,  32'd0,         6'd0,  32'd0,         4'd0}, 1'b1, BLANK_OK},
        '{'{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'd0,         4'd0}, 1'b1, NO_ROUTE},
        '{'{FUNC_LOOKUP, 32'h0000_0000, 6'd0,  32'd0,         4'd0}, 1'b1, NO_ROUTE}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [1:0]  i_func       = FUNC_NONE;
    logic [31:0] i_address    = 32'd0;
    logic [5:0]  i_prefix_len = 6'd0;
    logic [31:0] i_next_hop   = 32'd0;
    logic [3:0]  i_intf_id    = 4'd0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [4:0]  o_slot;
    logic [31:0] o_route_next_hop;
    logic [3:0]  o_route_intf;
    logic [5:0]  o_route_prefix_len;
    logic        o_used_default;

    // sideband that travels with each word: hand-written result, if any
    logic          pinned_en  = 1'b0;
    t_route_result pinned_res = '0;

    route_longest_prefix_lookup u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_address          (i_address),
        .i_prefix_len       (i_prefix_len),
        .i_next_hop         (i_next_hop),
        .i_intf_id          (i_intf_id),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_slot             (o_slot),
        .o_route_next_hop   (o_route_next_hop),
        .o_route_intf       (o_route_intf),
        .o_route_prefix_len (o_route_prefix_len),
        .o_used_default     (o_used_default)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Route table shadow: routes live in add order, slots below the count
    // are the live ones; clear just drops the count.
    // ------------------------------------------------------------------
    logic [31:0] tbl_dest    [ROUTE_SLOTS];
    logic [5:0]  tbl_len     [ROUTE_SLOTS];
    logic [31:0] tbl_gateway [ROUTE_SLOTS];
    logic [3:0]  tbl_port    [ROUTE_SLOTS];
    int          tbl_count = 0;

    t_route_result pending_results [$];
    int            mismatches  = 0;
    int            quiet_cycles = 0;

    function automatic t_route_result stored_route(input int idx);
        t_route_result r;
        r.status       = STATUS_OK;
        r.slot         = idx[4:0];
        r.next_hop     = tbl_gateway[idx];
        r.intf         = tbl_port[idx];
        r.prefix_len   = tbl_len[idx];
        r.used_default = (tbl_dest[idx] == 32'd0);
        return r;
    endfunction

    // Applies one word to the shadow table and returns the result it must give.
    function automatic t_route_result route_table_step(input t_route_cmd c);
        t_route_result r;
        int            best;
        int            dflt;
        int            i;
        logic [5:0]    best_len;
        logic [5:0]    ln;
        logic [63:0]   span;
        r        = '0;
        r.status = STATUS_OK;
        case (c.func)
            FUNC_ADD: begin
                if (tbl_count >= ROUTE_SLOTS) begin
                    r.status = STATUS_FULL;
                end else begin
                    tbl_dest[tbl_count]    = c.address;
                    tbl_len[tbl_count]     = (c.prefix_len > MAX_PLEN) ? MAX_PLEN : c.prefix_len;
                    tbl_gateway[tbl_count] = c.next_hop;
                    tbl_port[tbl_count]    = c.intf_id;
                    r = stored_route(tbl_count);
                    tbl_count++;
                end
            end
            FUNC_LOOKUP: begin
                best     = -1;
                dflt     = -1;
                best_len = 6'd0;
                for (i = 0; i < tbl_count; i++) begin
                    ln = tbl_len[i];
                    if (tbl_dest[i] == 32'd0) begin
                        if (dflt < 0) dflt = i;
                    end else if (ln != 6'd0) begin
                        // lower half of the shifted word holds the top-ln mask
                        span = 64'hFFFF_FFFF_0000_0000 >> ln;
                        // >= so the newest route takes a tie
                        if (((c.address ^ tbl_dest[i]) & span[31:0]) == 32'd0 &&
                            ln >= best_len) begin
                            best     = i;
                            best_len = ln;
                        end
                    end
                end
                if (best >= 0) begin
                    r = stored_route(best);
                end else if (dflt >= 0) begin
                    r = stored_route(dflt);
                end else begin
                    r.status = STATUS_MISS;
                end
            end
            FUNC_CLEAR: begin
                tbl_count = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted word, check each strobed result
    // against the oldest prediction. Sampled at the edge, so both sides
    // see pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_route_cmd    c;
        t_route_result want;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                c    = '{i_func, i_address, i_prefix_len, i_next_hop, i_intf_id};
                want = route_table_step(c);
                if (pinned_en) want = pinned_res;
                pending_results.push_back(want);
                moved = 1'b1;
            end
            if (o_strobe) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: status 0x%0h slot %0d",
                           o_status, o_slot);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("slot", 32'(want.slot), 32'(o_slot));
                    check_field("route_next_hop", want.next_hop, o_route_next_hop);
                    check_field("route_intf", 32'(want.intf), 32'(o_route_intf));
                    check_field("route_prefix_len", 32'(want.prefix_len),
                                32'(o_route_prefix_len));
                    check_field("used_default", 32'(want.used_default),
                                32'(o_used_default));
                end
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Watchdog: too long with no word going in or coming out.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one word; idle first with the given odds per cycle, then hold
    // start until the block takes it (busy low at the edge).
    task automatic send_cmd(input t_route_cmd c, input logic pin,
                            input t_route_result pin_res, input int unsigned idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start        <= 1'b1;
        i_func       <= c.func;
        i_address    <= c.address;
        i_prefix_len <= c.prefix_len;
        i_next_hop   <= c.next_hop;
        i_intf_id    <= c.intf_id;
        pinned_en    <= pin;
        pinned_res   <= pin_res;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending until every pending result has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Stimulus-side view of the routes, used to aim lookups at real prefixes.
    logic [31:0] gen_dest [$];
    logic [5:0]  gen_len  [$];

    localparam logic [31:0] PREFIX_POOL [8] = '{
        32'h0A00_0000, 32'hC0A8_0000, 32'hAC10_0000, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h0A0A_0000, 32'hC0A8_0100, 32'h0000_0001
    };

    function automatic logic [1:0] pick_func();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2) return FUNC_NONE;
        if (r < 4) return FUNC_CLEAR;
        if (r < 45) return FUNC_ADD;
        return FUNC_LOOKUP;
    endfunction

    function automatic t_route_cmd next_route_cmd(input logic [1:0] fn);
        t_route_cmd  c;
        int unsigned r;
        int unsigned k;
        logic [5:0]  eff;
        c.func       = fn;
        c.address    = $urandom;
        c.prefix_len = 6'($urandom_range(63));
        c.next_hop   = $urandom;
        c.intf_id    = 4'($urandom_range(15));
        case (fn)
            FUNC_ADD: begin
                r = $urandom_range(99);
                // mostly legal lengths, some past 32 to hit saturation
                c.prefix_len = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63))
                                                        : 6'($urandom_range(32));
                eff = (c.prefix_len > MAX_PLEN) ? MAX_PLEN : c.prefix_len;
                if (r < 12) begin
                    c.address = 32'd0;                         // default route
                end else if (r < 65) begin
                    c.address = PREFIX_POOL[$urandom_range(7)];
                    if ($urandom_range(1) != 0) c.address |= $urandom >> eff;
                end
                if ($urandom_range(4) == 0) c.next_hop = 32'd0;  // directly attached
                if (gen_dest.size() < ROUTE_SLOTS) begin
                    gen_dest.push_back(c.address);
                    gen_len.push_back(eff);
                end
            end
            FUNC_LOOKUP: begin
                r = $urandom_range(99);
                if (r < 65 && gen_dest.size() != 0) begin
                    k = $urandom_range(gen_dest.size() - 1);
                    // keep the route's prefix, scramble the host bits
                    c.address = gen_dest[k] ^ ($urandom >> gen_len[k]);
                end else if (r < 70) begin
                    c.address = 32'd0;
                end else if (r < 75) begin
                    c.address = 32'hFFFF_FFFF;
                end
            end
            FUNC_CLEAR: begin
                gen_dest.delete();
                gen_len.delete();
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          n;
        int unsigned pct;
        logic [1:0]  fn;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, sender idling a third of the time
        for (n = 0; n < DIR_ROWS; n++) begin
            send_cmd(directed_rows[n].cmd, directed_rows[n].pinned,
                     directed_rows[n].res, 35);
        end
        // hold off until the table has answered everything
        wait_drained();

        // random: light idling, heavy idling, then back to back
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3 || n == 2 * RAND_ITEMS / 3) wait_drained();
            pct = (n < RAND_ITEMS / 3) ? 35 : (n < 2 * RAND_ITEMS / 3) ? 62 : 0;
            // open with a fill past capacity so lookups see a full table
            if (n == 0)       fn = FUNC_CLEAR;
            else if (n <= 34) fn = FUNC_ADD;
            else              fn = pick_func();
            send_cmd(next_route_cmd(fn), 1'b0, '0, pct);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
